// ===== hdl/adlog_pkg.sv =====
// types, constants and helpers shared by the attach/detach ring log
`timescale 1ns / 1ps
package adlog_pkg;

  localparam int LOG_DEPTH = 16;
  localparam int PTR_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int POS_W     = 4;
  localparam int ID_W      = 16;
  localparam int TIME_W    = 32;
  localparam int ENTRY_W   = 5;
  localparam int SUM_W     = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    K_ATTACH = 2'd0,
    K_DETACH = 2'd1,
    K_CLEAR  = 2'd2,
    K_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MATCH = 2'd1,
    STAT_NOT_HELD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   vendor;
    logic [ID_W-1:0]   product;
    logic [ID_W-1:0]   handle;
    logic [TIME_W-1:0] connect;
    logic [TIME_W-1:0] disconnect;
    logic [TIME_W-1:0] span;
    logic              active;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_dec = (p == '0) ? PTR_W'(LOG_DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

// ===== hdl/adlog_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module adlog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/attach_detach_event_ring_log.sv =====
// top level of the attach/detach event ring log
//
//  channel  signals                  direction  payload
//  ev       ev_valid / ev_ready      in         kind, ids, now_seconds, position
//  res      res_valid / res_ready    out        status, entry_count, rd_* fields
//
// attach, clear and read: the transfer passes the execute and finish states; the result is registered leaving finish
// detach: scans back from the newest entry over at most entry count entries, one ring entry compared per cycle
// the single record ram port pair sets the scan rate; ev_ready is high only when idle
// a waiting result does not block the next transfer; only loading a new result waits
// synchronous reset empties the log; ram contents are not cleared
`timescale 1ns / 1ps
module attach_detach_event_ring_log (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ev_valid,
  output logic                            ev_ready,
  input  logic [1:0]                      kind,
  input  logic [adlog_pkg::ID_W-1:0]      vendor_code,
  input  logic [adlog_pkg::ID_W-1:0]      product_code,
  input  logic [adlog_pkg::ID_W-1:0]      device_handle,
  input  logic [adlog_pkg::TIME_W-1:0]    now_seconds,
  input  logic [adlog_pkg::POS_W-1:0]     position,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      status,
  output logic [adlog_pkg::ENTRY_W-1:0]   entry_count,
  output logic [adlog_pkg::ID_W-1:0]      rd_vendor,
  output logic [adlog_pkg::ID_W-1:0]      rd_product,
  output logic [adlog_pkg::ID_W-1:0]      rd_handle,
  output logic [adlog_pkg::TIME_W-1:0]    rd_connect_time,
  output logic                            rd_removed,
  output logic [adlog_pkg::TIME_W-1:0]    rd_disconnect_time,
  output logic [adlog_pkg::TIME_W-1:0]    rd_duration
);

  import adlog_pkg::*;

  state_t state, state_next;

  ptr_t write_ptr, write_ptr_next;
  ptr_t oldest_ptr, oldest_ptr_next;
  cnt_t held_count, held_count_next;

  kind_t             kind_q;
  logic [ID_W-1:0]   vendor_q, product_q, handle_q;
  logic [TIME_W-1:0] now_q;
  logic [POS_W-1:0]  pos_q;

  ptr_t    scan_addr, scan_addr_next;
  cnt_t    scan_i, scan_i_next;
  logic    chk_valid, chk_valid_next;
  ptr_t    chk_addr, chk_addr_next;
  status_t stat, stat_next;
  logic    read_ok, read_ok_next;

  logic       ram_we, ram_re;
  ptr_t       ram_waddr, ram_raddr;
  rec_t       ram_wdata, ram_rdata;

  logic       ev_xfer, load_res, scan_issue, matched, pos_ok;
  logic [SUM_W-1:0] rd_sum;
  ptr_t       rd_idx;

  assign ev_ready = (state == S_IDLE);
  assign ev_xfer  = ev_valid && ev_ready;
  assign load_res = (state == S_FINISH) && (!res_valid || res_ready);

  // read address wraps once at most
  assign pos_ok = (SUM_W'(pos_q) < SUM_W'(held_count));
  always_comb begin
    rd_sum = SUM_W'(oldest_ptr) + SUM_W'(pos_q);
    if (rd_sum >= SUM_W'(LOG_DEPTH)) begin
      rd_sum = rd_sum - SUM_W'(LOG_DEPTH);
    end
    rd_idx = rd_sum[PTR_W-1:0];
  end

  assign scan_issue = (scan_i < held_count);
  assign matched    = chk_valid && ram_rdata.active && (ram_rdata.vendor == vendor_q) &&
                      (ram_rdata.product == product_q) && (ram_rdata.handle == handle_q);

  adlog_ram #(
    .WIDTH(REC_W),
    .DEPTH(LOG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ev_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (kind_q == K_DETACH) ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        if (matched || (!scan_issue && !chk_valid)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_res) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    write_ptr_next  = write_ptr;
    oldest_ptr_next = oldest_ptr;
    held_count_next = held_count;
    scan_addr_next  = scan_addr;
    scan_i_next     = scan_i;
    chk_valid_next  = chk_valid;
    chk_addr_next   = chk_addr;
    stat_next       = stat;
    read_ok_next    = read_ok;
    ram_we          = 1'b0;
    ram_waddr       = write_ptr;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = rd_idx;
    case (state)
      S_EXEC: begin
        stat_next    = STAT_OK;
        read_ok_next = 1'b0;
        case (kind_q)
          K_ATTACH: begin
            ram_we            = 1'b1;
            ram_waddr         = write_ptr;
            ram_wdata.vendor  = vendor_q;
            ram_wdata.product = product_q;
            ram_wdata.handle  = handle_q;
            ram_wdata.connect = now_q;
            ram_wdata.active  = 1'b1;
            write_ptr_next    = ptr_inc(write_ptr);
            if (held_count < CNT_W'(LOG_DEPTH)) begin
              held_count_next = cnt_t'(held_count + 1'b1);
            end else begin
              oldest_ptr_next = ptr_inc(oldest_ptr);
            end
          end
          K_DETACH: begin
            stat_next      = STAT_NO_MATCH;
            scan_addr_next = ptr_dec(write_ptr);
            scan_i_next    = '0;
            chk_valid_next = 1'b0;
          end
          K_CLEAR: begin
            write_ptr_next  = '0;
            oldest_ptr_next = '0;
            held_count_next = '0;
          end
          K_READ: begin
            if (pos_ok) begin
              ram_re       = 1'b1;
              read_ok_next = 1'b1;
            end else begin
              stat_next = STAT_NOT_HELD;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        ram_raddr      = scan_addr;
        ram_re         = scan_issue;
        chk_valid_next = scan_issue;
        chk_addr_next  = scan_addr;
        if (scan_issue) begin
          scan_addr_next = ptr_dec(scan_addr);
          scan_i_next    = cnt_t'(scan_i + 1'b1);
        end
        if (matched) begin
          ram_we               = 1'b1;
          ram_waddr            = chk_addr;
          ram_wdata            = ram_rdata;
          ram_wdata.active     = 1'b0;
          ram_wdata.disconnect = now_q;
          ram_wdata.span       = now_q - ram_rdata.connect;
          stat_next            = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_ptr  <= '0;
      oldest_ptr <= '0;
      held_count <= '0;
      chk_valid  <= 1'b0;
      read_ok    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      write_ptr  <= write_ptr_next;
      oldest_ptr <= oldest_ptr_next;
      held_count <= held_count_next;
      chk_valid  <= chk_valid_next;
      read_ok    <= read_ok_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    scan_i    <= scan_i_next;
    chk_addr  <= chk_addr_next;
    stat      <= stat_next;
    if (ev_xfer) begin
      kind_q    <= kind_t'(kind);
      vendor_q  <= vendor_code;
      product_q <= product_code;
      handle_q  <= device_handle;
      now_q     <= now_seconds;
      pos_q     <= position;
    end
    if (load_res) begin
      status             <= stat;
      entry_count        <= ENTRY_W'(held_count);
      rd_vendor          <= read_ok ? ram_rdata.vendor : '0;
      rd_product         <= read_ok ? ram_rdata.product : '0;
      rd_handle          <= read_ok ? ram_rdata.handle : '0;
      rd_connect_time    <= read_ok ? ram_rdata.connect : '0;
      rd_removed         <= read_ok && !ram_rdata.active;
      rd_disconnect_time <= (read_ok && !ram_rdata.active) ? ram_rdata.disconnect : '0;
      rd_duration        <= (read_ok && !ram_rdata.active) ? ram_rdata.span : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(LOG_DEPTH))
    else $error("held count above log depth");

  a_partial_ring: assert property (@(posedge clk) disable iff (rst)
    (held_count < CNT_W'(LOG_DEPTH)) |-> (oldest_ptr == '0 && write_ptr == PTR_W'(held_count)))
    else $error("pointers disagree with count while log not full");

  a_full_ring: assert property (@(posedge clk) disable iff (rst)
    (held_count == CNT_W'(LOG_DEPTH)) |-> (write_ptr == oldest_ptr))
    else $error("head and tail differ on a full log");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EXEC || state == S_SCAN))
    else $error("record write outside execute or scan");

  a_transfer_exec: assert property (@(posedge clk) disable iff (rst)
    ev_xfer |=> (state == S_EXEC))
    else $error("accepted transfer did not start execution");
`endif

endmodule
